FILE: rtl/sfrp_pkg.sv
// sfrp_pkg: shared widths, register codes and the controller/datapath
// command and status structs of the symmetric fir row prefilter
// no dependencies
package sfrp_pkg;

  localparam int MAX_COEFFS_DEF   = 5;
  localparam int MAX_CHANNELS_DEF = 4;
  localparam int SAMPLE_BITS_DEF  = 32;

  localparam int COEFF_REGS = 5;
  localparam int SAMPLE_W   = 32;
  localparam int FIELD_W    = 3;
  localparam int COEFF_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TAP_W      = 3;
  localparam int PAIR_W     = SAMPLE_W + 2;
  localparam int PROD_W     = PAIR_W + COEFF_W;
  localparam int ACC_W      = 52;
  localparam int TOT_W      = 20;
  localparam int DIV_CNT_W  = $clog2(ACC_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_COUNT  = 3'd0,
    REG_CHANNELS     = 3'd1,
    REG_SAMPLE_BYTES = 3'd2,
    REG_COEFF_CENTRE = 3'd3,
    REG_COEFF_1      = 3'd4,
    REG_COEFF_2      = 3'd5,
    REG_COEFF_3      = 3'd6,
    REG_COEFF_4      = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUT_PASS,
    OUT_ZERO,
    OUT_QUOT
  } out_sel_t;

  typedef struct packed {
    logic             accept;
    logic             pairs;
    logic             mul;
    logic             add;
    logic             div_init;
    logic             div_step;
    logic             load_out;
    out_sel_t         out_sel;
    logic [TAP_W-1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic             pass_thru;
    logic             warm;
    logic             total_zero;
    logic             out_busy;
    logic [TAP_W-1:0] c_last;
  } status_t;

endpackage

FILE: rtl/sfrp_ifs.sv
// sfrp_pix_in_if, sfrp_pix_out_if, sfrp_cfg_if: valid/ready channels of
// the prefilter; widths from sfrp_pkg
interface sfrp_pix_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfrp_pkg::SAMPLE_W-1:0] sample;
  logic                          row_end;
  modport source (output valid, output sample, output row_end, input ready);
  modport sink (input valid, input sample, input row_end, output ready);
endinterface

interface sfrp_pix_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfrp_pkg::SAMPLE_W-1:0] filtered;
  logic                          zero_total;
  logic                          last_of_row;
  modport source (output valid, output filtered, output zero_total, output last_of_row,
                  input ready);
  modport sink (input valid, input filtered, input zero_total, input last_of_row,
                output ready);
endinterface

interface sfrp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sfrp_pkg::CFG_IDX_W-1:0]  index;
  logic [sfrp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sfrp_ctrl.sv
// sfrp_ctrl: sequencer of the prefilter, steps the datapath through
// window update, multiply-accumulate, bit-serial divide and result beat
// depends on sfrp_pkg
module sfrp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sfrp_pkg::status_t status,
  output sfrp_pkg::cmd_t    cmd,
  output logic              in_ready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAIRS,
    S_MUL,
    S_ADD,
    S_DIV_INIT,
    S_DIV_STEP,
    S_WRITE
  } state_t;

  state_t                           state;
  logic [sfrp_pkg::TAP_W-1:0]       tap;
  logic [sfrp_pkg::DIV_CNT_W-1:0]   div_cnt;
  sfrp_pkg::out_sel_t               out_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tap     <= '0;
      div_cnt <= '0;
      out_sel <= sfrp_pkg::OUT_PASS;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (status.pass_thru) begin
              out_sel <= sfrp_pkg::OUT_PASS;
              state   <= S_WRITE;
            end else if (status.warm) begin
              state <= S_PAIRS;
            end
          end
        end
        S_PAIRS: begin
          tap   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          if (tap == status.c_last) begin
            state <= S_DIV_INIT;
          end else begin
            tap   <= tap + 1'b1;
            state <= S_MUL;
          end
        end
        S_DIV_INIT: begin
          if (status.total_zero) begin
            out_sel <= sfrp_pkg::OUT_ZERO;
            state   <= S_WRITE;
          end else begin
            div_cnt <= '0;
            state   <= S_DIV_STEP;
          end
        end
        S_DIV_STEP: begin
          if (div_cnt == sfrp_pkg::DIV_CNT_W'(sfrp_pkg::ACC_W - 1)) begin
            out_sel <= sfrp_pkg::OUT_QUOT;
            state   <= S_WRITE;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_WRITE: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.tap     = tap;
    cmd.out_sel = out_sel;
    unique case (state)
      S_IDLE:     cmd.accept   = in_valid;
      S_PAIRS:    cmd.pairs    = 1'b1;
      S_MUL:      cmd.mul      = 1'b1;
      S_ADD:      cmd.add      = 1'b1;
      S_DIV_INIT: cmd.div_init = !status.total_zero;
      S_DIV_STEP: cmd.div_step = 1'b1;
      S_WRITE:    cmd.load_out = !status.out_busy;
      default:    cmd.accept   = 1'b0;
    endcase
  end

endmodule

FILE: rtl/sfrp_datapath.sv
// sfrp_datapath: configuration registers, per-channel tap lines, pair
// adders, multiply-accumulate, restoring divider and output register
// depends on sfrp_pkg
module sfrp_datapath #(
  parameter int MAX_COEFFS   = sfrp_pkg::MAX_COEFFS_DEF,
  parameter int MAX_CHANNELS = sfrp_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = sfrp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [sfrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfrp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [sfrp_pkg::SAMPLE_W-1:0]   sample,
  input  logic                            row_end,
  input  logic                            out_ready,
  input  sfrp_pkg::cmd_t                  cmd,
  output sfrp_pkg::status_t               status,
  output logic                            out_valid,
  output logic [sfrp_pkg::SAMPLE_W-1:0]   filtered,
  output logic                            zero_total,
  output logic                            last_of_row
);

  localparam int KMAX      = (MAX_COEFFS < sfrp_pkg::COEFF_REGS) ? MAX_COEFFS
                                                                 : sfrp_pkg::COEFF_REGS;
  localparam int WIN_TAPS  = 2 * KMAX - 1;
  localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CHN_W     = $clog2(MAX_CHANNELS + 1);
  localparam int MAX_BYTES = SAMPLE_BITS / 8;
  localparam int FILL_SAT  = 2 * (KMAX - 1);
  localparam int FILL_W    = $clog2(FILL_SAT + 2);
  localparam int OPND_IW   = (KMAX > 1) ? $clog2(KMAX) : 1;
  localparam int SW        = sfrp_pkg::SAMPLE_W;
  localparam int PW        = sfrp_pkg::PAIR_W;
  localparam int AW        = sfrp_pkg::ACC_W;
  localparam int TW        = sfrp_pkg::TOT_W;

  // configuration registers
  logic [sfrp_pkg::FIELD_W-1:0]       coeff_count;
  logic [sfrp_pkg::FIELD_W-1:0]       channels;
  logic [sfrp_pkg::FIELD_W-1:0]       sample_bytes;
  logic signed [sfrp_pkg::COEFF_W-1:0] coeff [sfrp_pkg::COEFF_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_count  <= sfrp_pkg::FIELD_W'(1);
      channels     <= sfrp_pkg::FIELD_W'(1);
      sample_bytes <= sfrp_pkg::FIELD_W'(1);
      coeff[0]     <= sfrp_pkg::COEFF_W'(1);
      for (int i = 1; i < sfrp_pkg::COEFF_REGS; i++) begin
        coeff[i] <= '0;
      end
    end else if (cfg_valid) begin
      unique case (sfrp_pkg::cfg_reg_t'(cfg_index))
        sfrp_pkg::REG_COEFF_COUNT:  coeff_count  <= cfg_data[sfrp_pkg::FIELD_W-1:0];
        sfrp_pkg::REG_CHANNELS:     channels     <= cfg_data[sfrp_pkg::FIELD_W-1:0];
        sfrp_pkg::REG_SAMPLE_BYTES: sample_bytes <= cfg_data[sfrp_pkg::FIELD_W-1:0];
        sfrp_pkg::REG_COEFF_CENTRE: coeff[0]     <= cfg_data;
        sfrp_pkg::REG_COEFF_1:      coeff[1]     <= cfg_data;
        sfrp_pkg::REG_COEFF_2:      coeff[2]     <= cfg_data;
        sfrp_pkg::REG_COEFF_3:      coeff[3]     <= cfg_data;
        sfrp_pkg::REG_COEFF_4:      coeff[4]     <= cfg_data;
        default:                    coeff_count  <= coeff_count;
      endcase
    end
  end

  // clamped register values
  logic [sfrp_pkg::TAP_W-1:0]   k_eff;
  logic [sfrp_pkg::TAP_W-1:0]   c_eff;
  logic [CHN_W-1:0]             chans_eff;
  logic [sfrp_pkg::FIELD_W-1:0] bytes_eff;
  logic [SW-1:0]                mask;

  always_comb begin
    if (coeff_count == '0) begin
      k_eff = sfrp_pkg::TAP_W'(1);
    end else if (int'(coeff_count) > KMAX) begin
      k_eff = sfrp_pkg::TAP_W'(KMAX);
    end else begin
      k_eff = coeff_count;
    end
    c_eff = k_eff - 1'b1;

    if (channels == '0) begin
      chans_eff = CHN_W'(1);
    end else if (int'(channels) > MAX_CHANNELS) begin
      chans_eff = CHN_W'(MAX_CHANNELS);
    end else begin
      chans_eff = CHN_W'(channels);
    end

    if (sample_bytes == '0) begin
      bytes_eff = sfrp_pkg::FIELD_W'(1);
    end else if (int'(sample_bytes) > MAX_BYTES) begin
      bytes_eff = sfrp_pkg::FIELD_W'(MAX_BYTES);
    end else begin
      bytes_eff = sample_bytes;
    end

    for (int b = 0; b < SW / 8; b++) begin
      mask[8*b +: 8] = (b < int'(bytes_eff)) ? 8'hff : 8'h00;
    end
  end

  // row position
  logic [CH_W-1:0]   phase;
  logic [CH_W-1:0]   ch_eff;
  logic              ch_wrap;
  logic [FILL_W-1:0] fill;

  assign ch_eff  = (int'(phase) >= int'(chans_eff)) ? '0 : phase;
  assign ch_wrap = (int'(ch_eff) + 1 >= int'(chans_eff));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      fill  <= '0;
    end else if (cmd.accept) begin
      if (row_end) begin
        phase <= '0;
        fill  <= '0;
      end else if (ch_wrap) begin
        phase <= '0;
        if (fill != FILL_W'(FILL_SAT)) begin
          fill <= fill + 1'b1;
        end
      end else begin
        phase <= ch_eff + 1'b1;
      end
    end
  end

  // tap lines, newest at tap 0
  logic [SW-1:0]   win [MAX_CHANNELS][WIN_TAPS];
  logic [CH_W-1:0] cur_ch;
  logic [SW-1:0]   sample_q;
  logic            row_end_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
        for (int t = 0; t < WIN_TAPS; t++) begin
          win[ch][t] <= '0;
        end
      end
    end else if (cmd.accept) begin
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
        if (CH_W'(ch) == ch_eff) begin
          win[ch][0] <= sample;
          for (int t = 1; t < WIN_TAPS; t++) begin
            win[ch][t] <= win[ch][t-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_ch    <= ch_eff;
      sample_q  <= sample;
      row_end_q <= row_end;
    end
  end

  // centre and mirrored pair sums of the current channel
  logic [SW-1:0]        taps [WIN_TAPS];
  logic signed [PW-1:0] opnd_v [KMAX];
  logic signed [TW-1:0] total_v;

  always_comb begin
    for (int t = 0; t < WIN_TAPS; t++) begin
      taps[t] = win[cur_ch][t];
    end
    opnd_v[0] = '0;
    for (int cc = 0; cc < KMAX; cc++) begin
      if (c_eff == sfrp_pkg::TAP_W'(cc)) begin
        opnd_v[0] = PW'(taps[cc]);
      end
    end
    total_v = TW'(coeff[0]);
    for (int d = 1; d < KMAX; d++) begin
      opnd_v[d] = '0;
      for (int cc = d; cc < KMAX; cc++) begin
        if (c_eff == sfrp_pkg::TAP_W'(cc)) begin
          opnd_v[d] = PW'(taps[cc-d]) + PW'(taps[cc+d]);
        end
      end
      if (sfrp_pkg::TAP_W'(d) <= c_eff) begin
        total_v = total_v + (TW'(coeff[d]) <<< 1);
      end
    end
  end

  // multiply-accumulate
  logic signed [PW-1:0]               opnd [KMAX];
  logic signed [TW-1:0]               total;
  logic signed [sfrp_pkg::PROD_W-1:0] prod;
  logic signed [sfrp_pkg::PROD_W-1:0] prod_v;
  logic signed [AW-1:0]               acc;

  assign prod_v = sfrp_pkg::PROD_W'(coeff[cmd.tap])
                * sfrp_pkg::PROD_W'(opnd[cmd.tap[OPND_IW-1:0]]);

  always_ff @(posedge clk) begin
    if (cmd.pairs) begin
      opnd  <= opnd_v;
      total <= total_v;
      acc   <= '0;
    end
    if (cmd.mul) begin
      prod <= prod_v;
    end
    if (cmd.add) begin
      acc <= acc + AW'(prod);
    end
  end

  // restoring divider, one quotient bit per step
  logic          neg;
  logic [AW-1:0] dq;
  logic [TW-1:0] dvs;
  logic [TW-1:0] rem;
  logic [TW:0]   trial;
  logic          ge;

  assign trial = {rem, dq[AW-1]};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg <= acc[AW-1] ^ total[TW-1];
      dq  <= acc[AW-1] ? AW'(-acc) : AW'(acc);
      dvs <= total[TW-1] ? TW'(-total) : TW'(total);
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? TW'(trial - {1'b0, dvs}) : TW'(trial);
      dq  <= {dq[AW-2:0], ge};
    end
  end

  // output register
  logic [SW-1:0] quot;

  assign quot = neg ? SW'(-dq[SW-1:0]) : dq[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      last_of_row <= row_end_q;
      unique case (cmd.out_sel)
        sfrp_pkg::OUT_PASS: begin
          filtered   <= sample_q & mask;
          zero_total <= 1'b0;
        end
        sfrp_pkg::OUT_ZERO: begin
          filtered   <= '0;
          zero_total <= 1'b1;
        end
        sfrp_pkg::OUT_QUOT: begin
          filtered   <= quot & mask;
          zero_total <= 1'b0;
        end
        default: begin
          filtered   <= '0;
          zero_total <= 1'b0;
        end
      endcase
    end
  end

  assign status.pass_thru  = (c_eff == '0);
  assign status.warm       = (int'(fill) >= 2 * int'(c_eff));
  assign status.total_zero = (total == '0);
  assign status.out_busy   = out_valid && !out_ready;
  assign status.c_last     = c_eff;

endmodule

FILE: rtl/symmetric_fir_row_prefilter_core.sv
// symmetric_fir_row_prefilter_core: top level, joins sequencer and datapath
// to the pixel and configuration channels; depends on sfrp_pkg, sfrp_ifs,
// sfrp_ctrl and sfrp_datapath
//
//   channel   dir  beat payload                          notes
//   pix_in    in   sample[31:0], row_end                 one component sample
//   pix_out   out  filtered[31:0], zero_total, last_of_row  registered
//   cfg       in   index[2:0], data[15:0]                ready always high
//
// a sample that gives no result is taken without leaving idle; a pass-through sample
// goes straight to the result beat; a filtered sample runs the tap loop and the
// 52-step bit-serial divider; a zero tap total skips the divider
// reset is synchronous and clears the tap lines at once, no clearing pass
// a stalled result holds in the output register; pix_in is taken again as
// soon as the result is loaded, without waiting for it to leave
module symmetric_fir_row_prefilter_core #(
  parameter int MAX_COEFFS   = sfrp_pkg::MAX_COEFFS_DEF,
  parameter int MAX_CHANNELS = sfrp_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_BITS  = sfrp_pkg::SAMPLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  sfrp_pix_in_if.sink    pix_in,
  sfrp_pix_out_if.source pix_out,
  sfrp_cfg_if.sink       cfg
);

  sfrp_pkg::cmd_t    cmd;
  sfrp_pkg::status_t status;

  assign cfg.ready = 1'b1;

  sfrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .status   (status),
    .cmd      (cmd),
    .in_ready (pix_in.ready)
  );

  sfrp_datapath #(
    .MAX_COEFFS   (MAX_COEFFS),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .sample      (pix_in.sample),
    .row_end     (pix_in.row_end),
    .out_ready   (pix_out.ready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (pix_out.valid),
    .filtered    (pix_out.filtered),
    .zero_total  (pix_out.zero_total),
    .last_of_row (pix_out.last_of_row)
  );

endmodule

FILE: rtl/sfrp_checker.sv
// sfrp_checker: port-level checks of the prefilter top level, attached by
// bind; depends on sfrp_pkg and symmetric_fir_row_prefilter_core
module sfrp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sfrp_pkg::SAMPLE_W-1:0] filtered,
  input logic                          zero_total
);

  // a result beat waits with its payload until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered))
    else $error("result beat dropped or changed while stalled");

  // a newly loaded result frees the input side in the same cycle
  a_rose_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("input not taken after result load");

  // zero tap total forces a zero result
  a_zero_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_total |-> filtered == '0)
    else $error("zero total with nonzero result");

  // no result beat straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat after reset");

endmodule

bind symmetric_fir_row_prefilter_core sfrp_checker u_sfrp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pix_in.ready),
  .out_valid  (pix_out.valid),
  .out_ready  (pix_out.ready),
  .filtered   (pix_out.filtered),
  .zero_total (pix_out.zero_total)
);
